FILE: hw/rtl/xfis_pkg.sv
package xfis_pkg;

    localparam int WIN_BYTES = 15;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(WIN_BYTES);
    localparam logic [LEN_W-1:0] LAST_IDX = LEN_W'(WIN_BYTES - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END     = 2'd2;

    localparam logic [7:0] OP_ESCAPE = 8'h0F;
    localparam logic [7:0] REX_LO    = 8'h40;
    localparam logic [7:0] REX_HI    = 8'h4F;

    localparam logic [1:0] MOD_REG  = 2'd3;
    localparam logic [1:0] MOD_IND  = 2'd0;
    localparam logic [1:0] MOD_D8   = 2'd1;
    localparam logic [1:0] MOD_D32  = 2'd2;
    localparam logic [2:0] RM_SIB   = 3'd4;
    localparam logic [2:0] RM_DISP  = 3'd5;

    typedef logic [WIN_BYTES-1:0][7:0] t_window;

    typedef struct packed {
        logic [63:0] fault_pc;
        logic        is_access_violation;
        logic [63:0] code_bytes_lo;
        logic [55:0] code_bytes_hi;
    } t_in_word;

    typedef struct packed {
        logic             handled;
        logic [LEN_W-1:0] instr_length;
        logic [63:0]      next_pc;
    } t_out_word;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] len;
    } t_dec_stat;

    function automatic logic is_legacy_prefix(input logic [7:0] b);
        logic r;
        case (b) inside
            8'h66, 8'h67, 8'hF2, 8'hF3, 8'h2E, 8'h3E,
            8'h26, 8'h36, 8'h64, 8'h65, 8'hF0: r = 1'b1;
            default:                            r = 1'b0;
        endcase
        return r;
    endfunction

    // one-byte opcodes that carry a ModRM byte (partial map)
    function automatic logic modrm_follows(input logic [7:0] op);
        logic r;
        case (op) inside
            [8'h80:8'h8F], [8'hD8:8'hDF], [8'hD0:8'hD3],
            8'h63, 8'h69, 8'h6B, 8'hC0, 8'hC1, 8'hC6, 8'hC7,
            8'hF6, 8'hF7, 8'hFE, 8'hFF:                  r = 1'b1;
            default: r = (op[7:6] == 2'b00) && (op[2:0] < 3'd6);
        endcase
        return r;
    endfunction

    function automatic logic [2:0] imm_bytes(input logic [7:0] op);
        logic [2:0] r;
        case (op) inside
            8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'h6B, 8'hC6: r = 3'd1;
            8'h81, 8'h69, 8'hC7:                             r = 3'd4;
            default:                                         r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/xfis_len_seq.sv
module xfis_len_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  xfis_pkg::t_window i_win,
    output xfis_pkg::t_dec_stat o_stat
);
    import xfis_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PFX   = 3'd1;
    localparam logic [2:0] S_REX   = 3'd2;
    localparam logic [2:0] S_OP    = 3'd3;
    localparam logic [2:0] S_MODRM = 3'd4;
    localparam logic [2:0] S_SIB   = 3'd5;
    localparam logic [2:0] S_TAIL  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [LEN_W-1:0] r_n, n_n;
    logic [1:0]       r_mod, n_mod;
    logic [2:0]       r_rm, n_rm;
    logic [2:0]       r_imm, n_imm;

    logic [7:0]       w_byte;
    logic [3:0]       w_inc;
    logic [3:0]       w_disp;
    logic [LEN_W:0]   w_sum;
    logic [LEN_W-1:0] w_n_add;
    logic             w_pfx;

    // byte under the pointer; past the window reads as zero
    assign w_byte = (r_n != LEN_MAX) ? i_win[r_n] : 8'h00;
    assign w_pfx  = is_legacy_prefix(w_byte);

    always_comb begin
        if (r_mod == MOD_IND && r_rm == RM_DISP) begin
            w_disp = 4'd4;
        end else if (r_mod == MOD_D8) begin
            w_disp = 4'd1;
        end else if (r_mod == MOD_D32) begin
            w_disp = 4'd4;
        end else begin
            w_disp = 4'd0;
        end
    end

    // increment for the shared pointer adder
    always_comb begin
        unique case (r_state)
            S_PFX:   w_inc = w_pfx ? 4'd1 : 4'd0;
            S_REX:   w_inc = (w_byte >= REX_LO && w_byte <= REX_HI) ? 4'd1 : 4'd0;
            S_OP:    w_inc = (w_byte == OP_ESCAPE) ? 4'd2 : 4'd1;
            S_MODRM: w_inc = 4'd1;
            S_SIB:   w_inc = (r_mod == MOD_IND && w_byte[2:0] == RM_DISP) ? 4'd5 : 4'd1;
            S_TAIL:  w_inc = w_disp + {1'b0, r_imm};
            default: w_inc = 4'd0;
        endcase
    end

    // saturates at the window size; any larger length clamps there anyway
    assign w_sum   = {1'b0, r_n} + {1'b0, w_inc};
    assign w_n_add = w_sum[LEN_W] ? LEN_MAX : w_sum[LEN_W-1:0];

    always_comb begin
        n_state = r_state;
        n_n     = w_n_add;
        n_mod   = r_mod;
        n_rm    = r_rm;
        n_imm   = r_imm;
        unique case (r_state)
            S_IDLE: begin
                n_n = '0;
                if (i_start) begin
                    n_state = S_PFX;
                    n_mod   = MOD_REG;
                    n_rm    = '0;
                    n_imm   = '0;
                end
            end
            S_PFX: begin
                if (!w_pfx) begin
                    n_state = S_REX;
                end else if (r_n == LAST_IDX) begin
                    n_state = S_DONE;
                end
            end
            S_REX: n_state = S_OP;
            S_OP: begin
                if (w_byte == OP_ESCAPE) begin
                    n_imm   = '0;
                    n_state = S_MODRM;
                end else begin
                    n_imm   = imm_bytes(w_byte);
                    n_state = modrm_follows(w_byte) ? S_MODRM : S_TAIL;
                end
            end
            S_MODRM: begin
                n_mod = w_byte[7:6];
                n_rm  = w_byte[2:0];
                if (w_byte[7:6] != MOD_REG && w_byte[2:0] == RM_SIB) begin
                    n_state = S_SIB;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_SIB:  n_state = S_TAIL;
            S_TAIL: n_state = S_DONE;
            S_DONE: begin
                n_n     = r_n;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n   <= n_n;
        r_mod <= n_mod;
        r_rm  <= n_rm;
        r_imm <= n_imm;
    end

    assign o_stat.done = (r_state == S_DONE);
    assign o_stat.len  = r_n;

endmodule

FILE: hw/rtl/x64_fault_instruction_skip_unit.sv
// Fault instruction skip unit.
// Input channel (i_in_valid / o_in_ready, i_in_word): one fault word with the
// faulting pc, the access-violation flag and 15 instruction bytes.
// Output channel (o_out_valid / i_out_ready, o_out_word): handled flag,
// instruction length (0 when not handled) and next pc = pc + length.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 handler enable,
// 1 region base, 2 region end (exclusive); always ready.
// A fault is handled when enabled, an access violation and base <= pc < end.
// An accepted word passes a check state, then the length decode when it is
// handled, then a finish state that loads the output register. The length
// sequencer walks prefixes, REX, opcode, ModRM, SIB and the displacement and
// immediate through a single pointer adder, so one word is in work at a time:
// o_in_ready is high only while idle. The result sits in an output register;
// a stalled receiver holds it there and the next word may be accepted and
// decoded meanwhile, finishing once the register is free.
// Reset (synchronous, active low) clears the config registers to zero and
// drops all valids.
module x64_fault_instruction_skip_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  xfis_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output xfis_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [xfis_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [63:0]                        i_cfg_data
);
    import xfis_pkg::*;

    localparam logic [1:0] T_IDLE   = 2'd0;
    localparam logic [1:0] T_CHECK  = 2'd1;
    localparam logic [1:0] T_DECODE = 2'd2;
    localparam logic [1:0] T_FINISH = 2'd3;

    logic [1:0]       r_state, n_state;
    logic             r_active;
    logic [63:0]      r_base, r_end;
    logic [63:0]      r_pc;
    logic             r_av;
    t_window          r_win;
    logic             r_ok;
    logic [LEN_W-1:0] r_len;
    logic             r_out_valid;
    t_out_word        r_out;

    logic             w_ok, w_start, w_slot_free, w_in_take;
    t_dec_stat        w_dec;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == T_IDLE);
    assign w_in_take   = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign w_ok    = r_active && r_av && (r_pc >= r_base) && (r_pc < r_end);
    assign w_start = (r_state == T_CHECK) && w_ok;

    xfis_len_seq u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_win   (r_win),
        .o_stat  (w_dec)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE:   if (w_in_take) n_state = T_CHECK;
            T_CHECK:  n_state = w_ok ? T_DECODE : T_FINISH;
            T_DECODE: if (w_dec.done) n_state = T_FINISH;
            T_FINISH: if (w_slot_free) n_state = T_IDLE;
            default:  n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_base      <= '0;
            r_end       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_HANDLER_ACTIVE: r_active <= i_cfg_data[0];
                    CFG_REGION_BASE:    r_base   <= i_cfg_data;
                    CFG_REGION_END:     r_end    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == T_FINISH && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_in_take) begin
            r_pc  <= i_in_word.fault_pc;
            r_av  <= i_in_word.is_access_violation;
            r_win <= {i_in_word.code_bytes_hi, i_in_word.code_bytes_lo};
        end
        if (r_state == T_CHECK) begin
            r_ok  <= w_ok;
            r_len <= '0;
        end
        if (r_state == T_DECODE && w_dec.done) begin
            r_len <= w_dec.len;
        end
        if (r_state == T_FINISH && w_slot_free) begin
            r_out.handled      <= r_ok;
            r_out.instr_length <= r_len;
            r_out.next_pc      <= r_pc + {{(64-LEN_W){1'b0}}, r_len};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: hw/rtl/xfis_checker.sv
module xfis_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  xfis_pkg::t_out_word            o_out_word
);
    import xfis_pkg::*;

    // a held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_unhandled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.handled |-> o_out_word.instr_length == '0)
        else $error("unhandled fault with nonzero length");

    a_handled_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.handled |-> o_out_word.instr_length != '0)
        else $error("handled fault with zero length");

    // one word in work at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after a take");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind x64_fault_instruction_skip_unit xfis_checker u_xfis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

FILE: tb/x64_fault_instruction_skip_unit_test.sv
`timescale 1ns / 100ps

module x64_fault_instruction_skip_unit_test;
    import xfis_pkg::*;

    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          RAND_PER_PHASE = 145;
    localparam logic [63:0] ADDR_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CODE_PC        = 64'h0000_7FF6_4A20_1000;

    // byte pools, first entry in the top byte
    localparam logic [87:0] PREFIX_BYTES = 88'h66_67_F2_F3_2E_3E_26_36_64_65_F0;
    localparam logic [79:0] IMM_OPS      = 80'h80_81_82_83_C0_C1_C6_C7_69_6B;
    localparam logic [63:0] MODRM_OPS    = 64'h63_F6_F7_FE_FF_D0_D1_D3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_word             i_in_word   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_HANDLER_ACTIVE;
    logic [63:0]          i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out_word            o_out_word;
    logic                 o_cfg_ready;

    // shadow of the handler registers
    logic        cfg_enable = 1'b0;
    logic [63:0] cfg_base   = '0;
    logic [63:0] cfg_end    = '0;

    t_out_word pending_skips[$];
    logic      fault_up   = 1'b0;
    logic      calm       = 1'b0;
    int        ready_hold = 0;
    int        cycles     = 0;
    int        mismatches = 0;
    int        n_faults   = 0;
    int        n_handled  = 0;
    int        n_clamped  = 0;
    int        n_settings = 0;

    x64_fault_instruction_skip_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d, %0d results outstanding", cycles,
                     pending_skips.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic is_prefix_byte(input logic [7:0] b);
        return b inside {8'h66, 8'h67, 8'hF2, 8'hF3, 8'h2E, 8'h3E,
                         8'h26, 8'h36, 8'h64, 8'h65, 8'hF0};
    endfunction

    function automatic logic takes_modrm(input logic [7:0] op);
        return (op[7:6] == 2'b00 && op[2:0] < 3'd6) || op[7:4] == 4'h8 ||
               op[7:3] == 5'b11011 || op[7:2] == 6'b110100 ||
               op inside {8'h63, 8'h69, 8'h6B, 8'hC0, 8'hC1, 8'hC6, 8'hC7,
                          8'hF6, 8'hF7, 8'hFE, 8'hFF};
    endfunction

    function automatic int imm_byte_count(input logic [7:0] op);
        if (op inside {8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'h6B, 8'hC6})
            return 1;
        if (op inside {8'h81, 8'h69, 8'hC7})
            return 4;
        return 0;
    endfunction

    // bytes past the window read as zero; they only push the length past the cap
    function automatic logic [7:0] byte_at(input t_window win, input int i);
        return (i < WIN_BYTES) ? win[i] : 8'h00;
    endfunction

    function automatic logic [LEN_W-1:0] insn_length(input t_window win);
        int         n;
        int         imm;
        logic       modrm;
        logic [7:0] op;
        logic [7:0] mrm;
        logic [7:0] sib;
        n = 0;
        imm = 0;
        while (n < WIN_BYTES && is_prefix_byte(win[n]))
            n++;
        if (n >= WIN_BYTES)
            return LEN_MAX;
        if (win[n] >= REX_LO && win[n] <= REX_HI)
            n++;
        op = byte_at(win, n);
        n++;
        if (op == OP_ESCAPE) begin
            n++;
            modrm = 1'b1;
        end else begin
            modrm = takes_modrm(op);
            imm = imm_byte_count(op);
        end
        if (modrm) begin
            mrm = byte_at(win, n);
            n++;
            if (mrm[7:6] != MOD_REG && mrm[2:0] == RM_SIB) begin
                sib = byte_at(win, n);
                n++;
                // SIB base 5 under mod 0: disp32, no base register
                if (mrm[7:6] == MOD_IND && sib[2:0] == RM_DISP)
                    n += 4;
            end
            if (mrm[7:6] == MOD_IND && mrm[2:0] == RM_DISP)
                n += 4;
            else if (mrm[7:6] == MOD_D8)
                n += 1;
            else if (mrm[7:6] == MOD_D32)
                n += 4;
        end
        n += imm;
        return (n > WIN_BYTES) ? LEN_MAX : LEN_W'(n);
    endfunction

    function automatic t_out_word predict_skip(input t_in_word w);
        t_out_word r;
        logic      hit;
        hit = cfg_enable && w.is_access_violation &&
              w.fault_pc >= cfg_base && w.fault_pc < cfg_end;
        r.handled      = hit;
        r.instr_length = hit ? insn_length({w.code_bytes_hi, w.code_bytes_lo}) : '0;
        r.next_pc      = w.fault_pc + 64'(r.instr_length);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_window random_window();
        logic [127:0] r;
        r = {$urandom(), $urandom(), $urandom(), $urandom()};
        return r[119:0];
    endfunction

    function automatic t_in_word pack_fault(input logic [63:0] pc, input logic av,
                                            input t_window win);
        t_in_word w;
        w.fault_pc            = pc;
        w.is_access_violation = av;
        w.code_bytes_lo       = win[7:0];
        w.code_bytes_hi       = win[14:8];
        return w;
    endfunction

    // lead holds nb bytes in reading order, the rest of the window is random
    function automatic t_in_word make_fault(input logic [63:0] pc, input logic av,
                                            input logic [119:0] lead, input int nb);
        t_window win;
        win = random_window();
        for (int i = 0; i < nb; i++)
            win[i] = lead[8 * (nb - 1 - i) +: 8];
        return pack_fault(pc, av, win);
    endfunction

    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(0, 6))
            0: return OP_ESCAPE;
            1: return IMM_OPS[8 * $urandom_range(0, 9) +: 8];
            2: return 8'($urandom_range(0, 63));
            3: return MODRM_OPS[8 * $urandom_range(0, 7) +: 8];
            4: return {5'b11011, 3'($urandom_range(0, 7))};
            5: return {4'h8, 4'($urandom_range(0, 15))};
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [63:0] pick_pc();
        logic [63:0] span;
        span = cfg_end - cfg_base;
        case ($urandom_range(0, 9))
            0: return cfg_base;
            1: return cfg_end - 64'd1;
            2: return cfg_end;
            3: return cfg_base - 64'd1;
            4: return rand64();
            default: return (cfg_end > cfg_base) ? cfg_base + rand64() % span : rand64();
        endcase
    endfunction

    // mostly well-formed instructions: prefixes, REX, opcode, steered ModRM
    function automatic t_in_word random_fault();
        t_window win;
        int      pos;
        int      prefixes;
        win = random_window();
        if ($urandom_range(0, 9) < 8) begin
            prefixes = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 15)
                                                   : $urandom_range(0, 3);
            pos = 0;
            repeat (prefixes) begin
                win[pos] = PREFIX_BYTES[8 * $urandom_range(0, 10) +: 8];
                pos++;
            end
            if (pos < WIN_BYTES && $urandom_range(0, 1)) begin
                win[pos] = REX_LO | 8'($urandom_range(0, 15));
                pos++;
            end
            if (pos < WIN_BYTES) begin
                win[pos] = pick_opcode();
                pos++;
            end
            if (pos < WIN_BYTES - 1 && $urandom_range(0, 2) == 0) begin
                win[pos][2:0] = $urandom_range(0, 1) ? RM_SIB : RM_DISP;
                if ($urandom_range(0, 1))
                    win[pos + 1][2:0] = RM_DISP;
            end
        end
        return pack_fault(pick_pc(), $urandom_range(0, 7) != 0, win);
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_fault(input t_in_word w);
        t_out_word want;
        if (!calm && $urandom_range(0, 3) == 0) begin
            if (fault_up) begin
                i_in_valid <= 1'b0;
                fault_up = 1'b0;
            end
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        fault_up = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        want = predict_skip(w);
        pending_skips.push_back(want);
        n_faults++;
        if (want.handled)
            n_handled++;
        if (want.handled && want.instr_length == LEN_MAX)
            n_clamped++;
    endtask

    task automatic hold_faults();
        if (fault_up) begin
            i_in_valid <= 1'b0;
            fault_up = 1'b0;
        end
        while (pending_skips.size() != 0)
            @(posedge i_clk);
    endtask

    // writes all three registers back to back, only once the unit is drained
    task automatic set_config(input logic enable, input logic [63:0] lo_addr,
                              input logic [63:0] hi_addr);
        logic [63:0] en_word;
        hold_faults();
        en_word = rand64();
        en_word[0] = enable;
        for (int k = 0; k < 3; k++) begin
            case (k)
                0: begin
                    i_cfg_index <= CFG_HANDLER_ACTIVE;
                    i_cfg_data  <= en_word;
                end
                1: begin
                    i_cfg_index <= CFG_REGION_BASE;
                    i_cfg_data  <= lo_addr;
                end
                default: begin
                    i_cfg_index <= CFG_REGION_END;
                    i_cfg_data  <= hi_addr;
                end
            endcase
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cfg_enable = enable;
        cfg_base   = lo_addr;
        cfg_end    = hi_addr;
        n_settings++;
    endtask

    // ---------------------------------------------------------------- checker

    task automatic note_mismatch(input string what, input t_out_word want,
                                 input t_out_word got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s at cycle %0d: exp handled=%0b len=%0d pc=%h, got handled=%0b len=%0d pc=%h",
                     what, cycles, want.handled, want.instr_length, want.next_pc,
                     got.handled, got.instr_length, got.next_pc);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_skips.size() == 0) begin
                    note_mismatch("unexpected word", '0, o_out_word);
                end else begin
                    want = pending_skips.pop_front();
                    if (o_out_word.handled !== want.handled ||
                        o_out_word.instr_length !== want.instr_length ||
                        o_out_word.next_pc !== want.next_pc)
                        note_mismatch("wrong word", want, o_out_word);
                end
            end
            if (ready_hold > 0) begin
                ready_hold--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                ready_hold = $urandom_range(0, 3);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // registers still at reset: empty region, nothing handled
    task automatic check_unconfigured();
        send_fault(make_fault(64'h0, 1'b1, 120'h90, 1));
        send_fault(make_fault(rand64(), 1'b1, 120'h488B0512345678, 7));
    endtask

    task automatic check_decode_corners();
        set_config(1'b1, 64'h0, ADDR_MAX);
        // prefix run over the whole window, then 14 prefixes ahead of an escape
        send_fault(make_fault(CODE_PC, 1'b1, 120'h6667F2F32E3E2636646566F0666766, 15));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h6667F2F32E3E2636646566F066670F, 15));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h90, 1));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h0F05C0, 3));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h4889C3, 3));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h488B0512345678, 7));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h8B442408, 4));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h8B042500100000, 7));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h81C078563412, 6));
        send_fault(make_fault(CODE_PC, 1'b1, 120'hC7042500100000EFBEADDE, 11));
        // decodes past 15 bytes, clamped
        send_fault(make_fault(CODE_PC, 1'b1, 120'h6667F2F32E48C78424001000007856, 15));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h6BC07F, 3));
        send_fault(make_fault(CODE_PC, 1'b1, 120'hD9E8, 2));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h3F, 1));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h4040, 2));
        send_fault(make_fault(CODE_PC, 1'b1, 120'hF64010, 3));
        send_fault(make_fault(CODE_PC, 1'b1, 120'h0, 15));
        send_fault(make_fault(CODE_PC, 1'b1, '1, 15));
    endtask

    task automatic check_region_edges();
        set_config(1'b0, 64'h0, ADDR_MAX);
        send_fault(make_fault(CODE_PC, 1'b1, 120'h90, 1));
        set_config(1'b1, 64'h8000, 64'h8000);
        send_fault(make_fault(64'h8000, 1'b1, 120'h90, 1));
        set_config(1'b1, ADDR_MAX, 64'h0);
        send_fault(make_fault(ADDR_MAX, 1'b1, 120'h90, 1));
        // region at the top of the address space; next pc wraps
        set_config(1'b1, ADDR_MAX - 64'd20, ADDR_MAX);
        send_fault(make_fault(ADDR_MAX - 64'd20, 1'b1, 120'h488B0512345678, 7));
        send_fault(make_fault(ADDR_MAX - 64'd1, 1'b1, 120'h488B0512345678, 7));
        send_fault(make_fault(ADDR_MAX, 1'b1, 120'h90, 1));
        send_fault(make_fault(ADDR_MAX - 64'd5, 1'b0, 120'h90, 1));
    endtask

    task automatic check_random_traffic();
        logic [63:0] addr;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_config(1'b1, 64'h0, ADDR_MAX);
                1: set_config(1'b1, 64'h1000_0000, 64'h1000_0400);
                2: set_config(1'b1, ADDR_MAX - 64'd40, ADDR_MAX);
                3: set_config(1'b0, 64'h0, ADDR_MAX);
                4: set_config(1'b1, rand64(), rand64());
                5: begin
                    addr = rand64();
                    set_config(1'b1, addr, addr);
                end
                default: begin
                    calm = 1'b1;
                    set_config(1'b1, 64'h4000_0000_0000, 64'h4000_0000_1000);
                end
            endcase
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                if (phase == 1 && k == RAND_PER_PHASE / 2)
                    hold_faults();
                send_fault(random_fault());
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_unconfigured();
        check_decode_corners();
        check_region_edges();
        check_random_traffic();
        hold_faults();
        repeat (40) @(posedge i_clk);
        $display("%0d faults over %0d register settings: %0d handled, %0d at the length cap",
                 n_faults, n_settings, n_handled, n_clamped);
        $display("%0d mismatches, %0d results outstanding", mismatches,
                 pending_skips.size());
        if (mismatches == 0 && pending_skips.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
